// ----- hw/rtl/crs_pkg.sv -----
// Shared widths, types and constants for the Catmull-Rom spline sampler.
package crs_pkg;

  localparam int PT_W = 32;
  localparam int CO_W = 36;
  localparam int ACC_W = 56;
  localparam int QB = PT_W - 1;
  localparam int DEF_SAMPLE_STEPS = 20;

  typedef logic signed [PT_W-1:0] pt_t;
  typedef logic signed [CO_W-1:0] co_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam pt_t PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam pt_t PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

endpackage

// ----- hw/rtl/catmull_rom_spline_sampler.sv -----
// Uniform Catmull-Rom spline sampler: takes 3D control points and emits sampled curve points.
// Control points enter on the in_ channel, a valid/ready pair with one transaction per point.
// in_path_start empties the held window so that the point begins a new path. Until three
// points are held a point is only stored. With three points held, each new point yields
// SAMPLE_STEPS+1 transactions on the out_ channel: the segment between the middle two
// points at t = k/SAMPLE_STEPS, the last one flagged by out_seg_last.
// After coefficient set-up for the three axes, each coordinate of a sample goes through one
// shared multiply-add unit (three Horner steps) and one divider that uses a reciprocal
// multiply and up to three correction subtractions; a coordinate that saturates skips the
// estimate and the corrections.
// A point that produces a segment keeps in_ready low until the last sample of the segment
// has been loaded into the output register.
// Results are held in an output register; the sequencer stalls on a sample while the
// receiver keeps out_ready low and the register is still full, and nothing is lost.
// Reset (rst_n low at a clock edge) empties the window and drops any pending result.
module catmull_rom_spline_sampler import crs_pkg::*; #(
  parameter int SAMPLE_STEPS = DEF_SAMPLE_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pt_t  in_pt_x,
  input  pt_t  in_pt_y,
  input  pt_t  in_pt_z,
  input  logic in_path_start,
  output logic out_valid,
  input  logic out_ready,
  output pt_t  out_smp_x,
  output pt_t  out_smp_y,
  output pt_t  out_smp_z,
  output logic out_seg_last
);

  localparam int K_W = $clog2(SAMPLE_STEPS + 1);
  localparam acc_t S1 = ACC_W'(SAMPLE_STEPS);
  localparam acc_t S2 = ACC_W'(SAMPLE_STEPS * SAMPLE_STEPS);
  localparam acc_t S3 = ACC_W'(SAMPLE_STEPS * SAMPLE_STEPS * SAMPLE_STEPS);
  localparam logic [K_W-1:0] K_LAST = K_W'(SAMPLE_STEPS);
  localparam logic [1:0] AX_LAST = 2'd2;
  localparam logic [1:0] HELD_FULL = 2'd3;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COEF   = 3'd1;
  localparam logic [2:0] ST_MAC    = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  logic [2:0]     st_r;
  logic [1:0]     held_r;
  logic [1:0]     axis_r;
  logic [1:0]     step_r;
  logic [K_W-1:0] k_r;
  logic           out_valid_r;

  pt_t  hist_r [3][3];
  pt_t  p3_r [3];
  co_t  d_r [3];
  acc_t cs_r [3];
  acc_t bs_r [3];
  acc_t as_r [3];
  pt_t  stage_r [3];
  pt_t  out_x_r;
  pt_t  out_y_r;
  pt_t  out_z_r;
  logic out_last_r;

  logic [1:0] held_eff;
  logic       need_seg;
  logic       in_acc;
  logic       out_load;
  logic       k_last;
  co_t        e0, e1, e2, e3;
  co_t        a_co, b_co, c_co, d_co;
  acc_t       cs_v, bs_v, as_v;
  acc_t       mac_a, mac_add, mac_acc;
  logic       mac_en;
  logic       div_start;
  logic       div_done;
  pt_t        div_quot;

  assign in_ready     = (st_r == ST_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign held_eff     = in_path_start ? 2'd0 : held_r;
  assign need_seg     = (held_eff == HELD_FULL);
  assign k_last       = (k_r == K_LAST);
  assign out_load     = (st_r == ST_PUSH) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_smp_x    = out_x_r;
  assign out_smp_y    = out_y_r;
  assign out_smp_z    = out_z_r;
  assign out_seg_last = out_last_r;

  assign e0   = CO_W'(hist_r[axis_r][0]);
  assign e1   = CO_W'(hist_r[axis_r][1]);
  assign e2   = CO_W'(hist_r[axis_r][2]);
  assign e3   = CO_W'(p3_r[axis_r]);
  assign a_co = e1 <<< 1;
  assign b_co = e2 - e0;
  assign c_co = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign d_co = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
  assign cs_v = ACC_W'(c_co) * S1;
  assign bs_v = ACC_W'(b_co) * S2;
  assign as_v = ACC_W'(a_co) * S3;

  assign mac_en    = (st_r == ST_MAC);
  assign div_start = (st_r == ST_DSTART);

  always_comb begin
    unique case (step_r)
      2'd0: begin
        mac_a   = ACC_W'(d_r[axis_r]);
        mac_add = cs_r[axis_r];
      end
      2'd1: begin
        mac_a   = mac_acc;
        mac_add = bs_r[axis_r];
      end
      default: begin
        mac_a   = mac_acc;
        mac_add = as_r[axis_r];
      end
    endcase
  end

  crs_mac #(
    .K_W (K_W)
  ) u_mac (
    .clk    (clk),
    .en     (mac_en),
    .mul_a  (mac_a),
    .k      (k_r),
    .addend (mac_add),
    .acc    (mac_acc)
  );

  crs_div #(
    .SAMPLE_STEPS (SAMPLE_STEPS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mac_acc),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      held_r      <= '0;
      axis_r      <= '0;
      step_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (need_seg) begin
              axis_r <= '0;
              st_r   <= ST_COEF;
            end else begin
              held_r <= held_eff + 2'd1;
            end
          end
        end
        ST_COEF: begin
          if (axis_r == AX_LAST) begin
            axis_r <= '0;
            step_r <= '0;
            k_r    <= '0;
            st_r   <= ST_MAC;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        ST_MAC: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            st_r <= ST_DSTART;
          end
        end
        ST_DSTART: begin
          st_r <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            step_r <= '0;
            if (axis_r == AX_LAST) begin
              st_r <= ST_PUSH;
            end else begin
              axis_r <= axis_r + 2'd1;
              st_r   <= ST_MAC;
            end
          end
        end
        ST_PUSH: begin
          if (out_load) begin
            axis_r <= '0;
            if (k_last) begin
              st_r <= ST_IDLE;
            end else begin
              k_r  <= k_r + 1'b1;
              st_r <= ST_MAC;
            end
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (need_seg) begin
        p3_r[0] <= in_pt_x;
        p3_r[1] <= in_pt_y;
        p3_r[2] <= in_pt_z;
      end else begin
        hist_r[0][held_eff] <= in_pt_x;
        hist_r[1][held_eff] <= in_pt_y;
        hist_r[2][held_eff] <= in_pt_z;
      end
    end
    if (st_r == ST_COEF) begin
      d_r[axis_r]  <= d_co;
      cs_r[axis_r] <= cs_v;
      bs_r[axis_r] <= bs_v;
      as_r[axis_r] <= as_v;
      if (axis_r == AX_LAST) begin
        for (int a = 0; a < 3; a++) begin
          hist_r[a][0] <= hist_r[a][1];
          hist_r[a][1] <= hist_r[a][2];
          hist_r[a][2] <= p3_r[a];
        end
      end
    end
    if (st_r == ST_DWAIT && div_done) begin
      stage_r[axis_r] <= div_quot;
    end
    if (out_load) begin
      out_x_r    <= stage_r[0];
      out_y_r    <= stage_r[1];
      out_z_r    <= stage_r[2];
      out_last_r <= k_last;
    end
  end

`ifndef SYNTHESIS
  a_busy_window_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> (held_r == HELD_FULL))
    else $error("Segment in progress without a full point window.");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DWAIT))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r <= K_LAST))
    else $error("Sample index ran past the end of the segment.");

  a_axis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (axis_r != 2'd3))
    else $error("Axis counter holds an invalid value.");
`endif

endmodule

// ----- hw/rtl/crs_mac.sv -----
// Registered multiply-add unit shared by every Horner step of the sampler.
module crs_mac import crs_pkg::*; #(
  parameter int K_W = $clog2(DEF_SAMPLE_STEPS + 1)
) (
  input  logic           clk,
  input  logic           en,
  input  acc_t           mul_a,
  input  logic [K_W-1:0] k,
  input  acc_t           addend,
  output acc_t           acc
);

  logic signed [K_W:0] k_s;
  acc_t                prod;
  acc_t                acc_r;

  assign k_s  = {1'b0, k};
  assign prod = ACC_W'(mul_a * k_s);
  assign acc  = acc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= prod + addend;
    end
  end

endmodule

// ----- hw/rtl/crs_div.sv -----
// Rounding divider by the constant 2*S^3 using a reciprocal multiply, with 32-bit saturation.
module crs_div import crs_pkg::*; #(
  parameter int SAMPLE_STEPS = DEF_SAMPLE_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  acc_t num,
  output logic done,
  output pt_t  quot
);

  localparam int DEN_I  = 2 * SAMPLE_STEPS * SAMPLE_STEPS * SAMPLE_STEPS;
  localparam int DEN_L  = $clog2(DEN_I);
  localparam int PROD_W = 2 * QB;
  localparam logic [ACC_W-1:0] HALF  = ACC_W'(SAMPLE_STEPS * SAMPLE_STEPS * SAMPLE_STEPS);
  localparam logic [ACC_W-1:0] DEN   = ACC_W'(DEN_I);
  localparam logic [ACC_W-1:0] LIMIT = DEN << QB;
  localparam logic [PT_W-1:0]  RECIP = PT_W'((64'd1 << (DEN_L + QB)) / 64'(DEN_I));

  localparam logic [2:0] DV_IDLE = 3'd0;
  localparam logic [2:0] DV_CHK  = 3'd1;
  localparam logic [2:0] DV_EST  = 3'd2;
  localparam logic [2:0] DV_REM  = 3'd3;
  localparam logic [2:0] DV_FIX  = 3'd4;
  localparam logic [2:0] DV_DONE = 3'd5;

  logic [2:0]        st_r;
  logic [ACC_W-1:0]  x_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  r_r;
  logic [QB-1:0]     q_r;
  logic              neg_r;
  logic              sat_r;
  logic [ACC_W-1:0]  mag;
  logic [QB-1:0]     t_v;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  qd;
  logic              ge;
  pt_t               q_ext;

  assign mag   = num[ACC_W-1] ? -num : num;
  assign t_v   = x_r[DEN_L+QB-1:DEN_L];
  assign prod  = PROD_W'(t_v) * PROD_W'(RECIP);
  assign qd    = ACC_W'(q_r) * DEN;
  assign ge    = (r_r >= DEN);
  assign q_ext = {1'b0, q_r};
  assign done  = (st_r == DV_DONE);

  always_comb begin
    if (sat_r) begin
      quot = neg_r ? PT_MIN : PT_MAX;
    end else begin
      quot = neg_r ? -q_ext : q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      unique case (st_r)
        DV_IDLE: begin
          if (start) begin
            st_r <= DV_CHK;
          end
        end
        DV_CHK: begin
          st_r <= (x_r >= LIMIT) ? DV_DONE : DV_EST;
        end
        DV_EST: begin
          st_r <= DV_REM;
        end
        DV_REM: begin
          st_r <= DV_FIX;
        end
        DV_FIX: begin
          if (!ge) begin
            st_r <= DV_DONE;
          end
        end
        DV_DONE: begin
          st_r <= DV_IDLE;
        end
        default: begin
          st_r <= DV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == DV_IDLE && start) begin
      neg_r <= num[ACC_W-1];
      x_r   <= mag + HALF;
    end
    if (st_r == DV_CHK) begin
      sat_r  <= (x_r >= LIMIT);
      prod_r <= prod;
    end
    if (st_r == DV_EST) begin
      q_r <= prod_r[PROD_W-1:QB];
    end
    if (st_r == DV_REM) begin
      r_r <= x_r - qd;
    end
    if (st_r == DV_FIX && ge) begin
      r_r <= r_r - DEN;
      q_r <= q_r + 1'b1;
    end
  end

endmodule
